// ===== rtl/core/nrle_pkg.sv =====
// Shared types and constants for the nibble run-length encoder.
// No dependencies; nrle_encoder, nrle_out_queue and the top level refer to this package.
package nrle_pkg;

  // Levels whose runs use the two-byte long form
  localparam logic [3:0]  LEVEL_BLACK   = 4'h0;
  localparam logic [3:0]  LEVEL_WHITE   = 4'hF;
  localparam logic [11:0] LONG_MAX_LEN  = 12'hFFF;
  localparam logic [11:0] SHORT_MAX_LEN = 12'h00F;

  // Up to two bytes for a run closed by a level change, two for the current run
  localparam int MAX_BURST   = 4;
  localparam int BURST_W     = $clog2(MAX_BURST + 1);
  localparam int QUEUE_DEPTH = 8;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] code_byte;
    logic       frame_last;
  } out_entry_t;

  // Bytes produced by one pixel, handed from the encoder to the output queue
  typedef struct packed {
    logic                          valid;
    logic [BURST_W-1:0]            count;
    out_entry_t [MAX_BURST-1:0]    entry;
  } burst_t;

  function automatic logic is_long_level(input logic [3:0] level);
    is_long_level = (level == LEVEL_BLACK) || (level == LEVEL_WHITE);
  endfunction

endpackage

// ===== rtl/core/nrle_if.sv =====
// Valid/ready channel interfaces for the pixel input and the code byte output.
// No dependencies.
interface nrle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       frame_end;

  modport source(output valid, output pixel_byte, output frame_end, input ready);
  modport sink(input valid, input pixel_byte, input frame_end, output ready);
endinterface

interface nrle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       frame_last;

  modport source(output valid, output code_byte, output frame_last, input ready);
  modport sink(input valid, input code_byte, input frame_last, output ready);
endinterface

// ===== rtl/core/nrle_encoder.sv =====
// Input register, run state and per-pixel byte generation.
// Depends on nrle_pkg and nrle_in_if.
module nrle_encoder (
  input  logic             clk,
  input  logic             rst_n,
  nrle_in_if.sink          in_ch,
  input  logic             space_ok,
  output nrle_pkg::burst_t burst
);

  logic        hold_valid_r;
  logic [3:0]  hold_level_r;
  logic        hold_last_r;

  logic [3:0]  run_level_r;
  logic [11:0] run_length_r;
  logic        run_open_r;

  logic        fire;
  logic        flush_old;
  logic        start_new;
  logic        old_long;
  logic        cur_long;
  logic        flush_cur;
  logic [11:0] cur_len;
  logic [11:0] max_len;
  logic [1:0]  n_old;
  logic [1:0]  n_cur;
  logic [nrle_pkg::BURST_W-1:0] total;
  logic [7:0]  old_b [2];
  logic [7:0]  cur_b [2];

  assign fire         = hold_valid_r && space_ok;
  assign in_ch.ready  = !hold_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      hold_valid_r <= 1'b1;
    end else if (fire) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      hold_level_r <= in_ch.pixel_byte[7:4];
      hold_last_r  <= in_ch.frame_end;
    end
  end

  always_comb begin
    flush_old = run_open_r && (hold_level_r != run_level_r);
    start_new = !run_open_r || flush_old;
    cur_len   = start_new ? 12'd1 : run_length_r + 12'd1;
    old_long  = nrle_pkg::is_long_level(run_level_r);
    cur_long  = nrle_pkg::is_long_level(hold_level_r);
    max_len   = cur_long ? nrle_pkg::LONG_MAX_LEN : nrle_pkg::SHORT_MAX_LEN;
    flush_cur = (cur_len >= max_len) || hold_last_r;

    old_b[0] = {run_level_r, old_long ? run_length_r[11:8] : run_length_r[3:0]};
    old_b[1] = run_length_r[7:0];
    cur_b[0] = {hold_level_r, cur_long ? cur_len[11:8] : cur_len[3:0]};
    cur_b[1] = cur_len[7:0];

    n_old = flush_old ? (old_long ? 2'd2 : 2'd1) : 2'd0;
    n_cur = flush_cur ? (cur_long ? 2'd2 : 2'd1) : 2'd0;
    total = nrle_pkg::BURST_W'(n_old) + nrle_pkg::BURST_W'(n_cur);

    burst.valid = fire;
    burst.count = total;
    for (int i = 0; i < nrle_pkg::MAX_BURST; i++) begin
      // closed run first, then the current run
      if (nrle_pkg::BURST_W'(i) < nrle_pkg::BURST_W'(n_old)) begin
        burst.entry[i].code_byte = old_b[i % 2];
      end else begin
        burst.entry[i].code_byte =
          cur_b[1'(nrle_pkg::BURST_W'(i) - nrle_pkg::BURST_W'(n_old))];
      end
      burst.entry[i].frame_last = hold_last_r &&
        (nrle_pkg::BURST_W'(i) == total - nrle_pkg::BURST_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_level_r  <= '0;
      run_length_r <= '0;
      run_open_r   <= 1'b0;
    end else if (fire) begin
      run_level_r <= hold_level_r;
      if (flush_cur) begin
        run_open_r   <= 1'b0;
        run_length_r <= '0;
      end else begin
        run_open_r   <= 1'b1;
        run_length_r <= cur_len;
      end
    end
  end

  a_open_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    run_open_r |-> run_length_r != '0)
    else $error("open run with zero length");

  a_frame_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    fire && hold_last_r |=> !run_open_r)
    else $error("run left open after frame end");

  a_frame_emits: assert property (@(posedge clk) disable iff (!rst_n)
    fire && hold_last_r |-> total != '0)
    else $error("frame end produced no byte");

endmodule

// ===== rtl/core/nrle_out_queue.sv =====
// Shifting output queue: takes a burst of up to four bytes, sends one per transfer.
// Depends on nrle_pkg and nrle_out_if.
module nrle_out_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  nrle_pkg::burst_t burst,
  output logic             space_ok,
  nrle_out_if.source       out_ch
);

  nrle_pkg::out_entry_t        slot_r   [nrle_pkg::QUEUE_DEPTH];
  nrle_pkg::out_entry_t        slot_nxt [nrle_pkg::QUEUE_DEPTH];
  logic [nrle_pkg::QCNT_W-1:0] count_r;
  logic [nrle_pkg::QCNT_W-1:0] count_nxt;
  logic [nrle_pkg::QCNT_W-1:0] base;
  logic                        pop;

  assign out_ch.valid      = count_r != '0;
  assign out_ch.code_byte  = slot_r[0].code_byte;
  assign out_ch.frame_last = slot_r[0].frame_last;
  // room for a full burst regardless of this cycle's transfer
  assign space_ok = count_r <= nrle_pkg::QCNT_W'(nrle_pkg::QUEUE_DEPTH - nrle_pkg::MAX_BURST);

  always_comb begin
    pop  = out_ch.valid && out_ch.ready;
    base = count_r - nrle_pkg::QCNT_W'(pop);
    for (int i = 0; i < nrle_pkg::QUEUE_DEPTH; i++) begin
      slot_nxt[i] = slot_r[i];
      if (nrle_pkg::QCNT_W'(i) < base) begin
        if (pop && i < nrle_pkg::QUEUE_DEPTH - 1) begin
          slot_nxt[i] = slot_r[i+1];
        end
      end else if (burst.valid &&
                   (nrle_pkg::QCNT_W'(i) - base) < nrle_pkg::QCNT_W'(burst.count)) begin
        slot_nxt[i] = burst.entry[2'(nrle_pkg::QCNT_W'(i) - base)];
      end
    end
    count_nxt = base + (burst.valid ? nrle_pkg::QCNT_W'(burst.count) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= nrle_pkg::QCNT_W'(nrle_pkg::QUEUE_DEPTH))
    else $error("output queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    burst.valid |-> space_ok)
    else $error("burst pushed without room");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    !burst.valid && !(out_ch.valid && out_ch.ready) |=> $stable(count_r))
    else $error("queue count moved without push or transfer");

endmodule

// ===== rtl/core/nibble_run_length_encoder_core.sv =====
// Top level of the nibble run-length encoder: pixel in, encoded bytes out.
// Depends on nrle_pkg, nrle_if, nrle_encoder and nrle_out_queue.
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+-----------------------------------
//   in_ch    | in  | valid/ready  | pixel_byte[7:0], frame_end
//   out_ch   | out | valid/ready  | code_byte[7:0], frame_last
//
// One pixel is taken per cycle when not stalled; each pixel waits in the input
// register until the queue holds at most four bytes, is then encoded, and its
// 0 to 4 bytes land in an 8-entry output queue. Bytes leave one per cycle while
// out_ch.ready is high; sustained input rate is one pixel per cycle as long as
// bytes per pixel average at most one. in_ch stalls while such a pixel waits.
// rst_n is synchronous: it clears the run state, input register and queue.
module nibble_run_length_encoder_core (
  input  logic       clk,
  input  logic       rst_n,
  nrle_in_if.sink    in_ch,
  nrle_out_if.source out_ch
);

  nrle_pkg::burst_t burst;
  logic             space_ok;

  nrle_encoder u_encoder (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .space_ok (space_ok),
    .burst    (burst)
  );

  nrle_out_queue u_out_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .burst    (burst),
    .space_ok (space_ok),
    .out_ch   (out_ch)
  );

endmodule
